// ===== sv/uv_sphere_tessellator_defines.svh =====
// assertion macros shared by the tessellator rtl
`ifndef UV_SPHERE_TESSELLATOR_DEFINES_SVH
`define UV_SPHERE_TESSELLATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define UVST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define UVST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/uvst_pkg.sv =====
// shared types, constants and helpers of the uv sphere tessellator
`default_nettype none
package uvst_pkg;

  localparam int RAD_W   = 16;
  localparam int CNT_W   = 11;
  localparam int IDX_W   = 10;
  localparam int CFG_W   = 16;
  localparam int COORD_W = 24;
  localparam int DEN_W   = 12;
  localparam int SC_W    = 32;
  localparam int T_W     = 31;
  localparam int T2_W    = 32;
  localparam int TERM_W  = 32;
  localparam int ACC_W   = 34;
  localparam int RING_W  = 26;

  // result buffer slots
  localparam int DEPTH  = 16;
  localparam int SLOT_W = 4;
  localparam int OCC_W  = 5;

  // taylor series cells: cos takes nine terms after the first, sin eight
  localparam int TAY_CELLS = 9;
  localparam int SIN_TERMS = 8;

  localparam logic [T_W-1:0]    HALF_PI_Q30 = 31'd1686629713;
  localparam logic [TERM_W-1:0] ONE_Q30     = 32'h4000_0000;

  typedef enum logic [1:0] {
    REG_RADIUS,
    REG_SLICES,
    REG_STACKS
  } cfg_reg_t;

  typedef enum logic [1:0] {
    JOB_LAT0,
    JOB_LAT1,
    JOB_LON0,
    JOB_LON1
  } job_kind_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    job_kind_t         kind;
    logic [1:0]        quad;
  } job_tag_t;

  typedef struct packed {
    logic [T2_W-1:0]          t2;
    logic [TERM_W-1:0]        term_s;
    logic [TERM_W-1:0]        term_c;
    logic signed [ACC_W-1:0]  acc_s;
    logic signed [ACC_W-1:0]  acc_c;
    job_tag_t                 tag;
  } tay_bus_t;

  // vertex n of the quad: {upper latitude, second longitude}
  function automatic logic [1:0] vtx_corner(input logic [2:0] n);
    case (n)
      3'd0: return 2'b00;
      3'd1: return 2'b10;
      3'd2: return 2'b11;
      3'd3: return 2'b00;
      3'd4: return 2'b11;
      3'd5: return 2'b01;
      default: return 2'b00;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== sv/uv_sphere_tessellator.sv =====
// Throughput: one vertex per cycle from the output multiplier pair when the output
// is not stalled by out_ready and the head slot is complete; the angle issuer takes
// a bad-index request through all its angle jobs, like any other request.
// Up to 16 requests may be in flight (result buffer slots).
// Reset: synchronous, clears control and sets radius 1.0 and 16 by 16 divisions.
`default_nettype none
`include "uv_sphere_tessellator_defines.svh"
module uv_sphere_tessellator import uvst_pkg::*; #(
  parameter int MAX_DIVISIONS = 1024,
  parameter int ANGLE_BITS    = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [1:0]                cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [IDX_W-1:0]          in_stack_index,
  input  logic [IDX_W-1:0]          in_slice_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] out_vertex_x,
  output logic signed [COORD_W-1:0] out_vertex_y,
  output logic signed [COORD_W-1:0] out_vertex_z,
  output logic                      out_last_vertex,
  output logic                      out_bad_index
);

  localparam int AB = ANGLE_BITS;
  localparam int QW = AB + 1;
  localparam int NW = AB + 12;
  localparam int PW = AB - 2 + T_W + 1;
  localparam logic [AB-1:0] QTR = AB'(1) << (AB - 2);

  // configuration registers
  logic [RAD_W-1:0] radius_r;
  logic [CNT_W-1:0] slices_r, stacks_r, cnt_clamp;

  always_comb begin
    cnt_clamp = cfg_wdata[CNT_W-1:0];
    if (32'(cnt_clamp) > MAX_DIVISIONS) cnt_clamp = CNT_W'(MAX_DIVISIONS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RAD_W'(256);
      slices_r <= CNT_W'(16);
      stacks_r <= CNT_W'(16);
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_RADIUS: radius_r <= cfg_wdata;
        REG_SLICES: slices_r <= cnt_clamp;
        REG_STACKS: stacks_r <= cnt_clamp;
        default: ;
      endcase
    end
  end

  // request intake and angle job issue
  logic              busy_r, busy_nxt;
  job_kind_t         job_r, job_nxt;
  logic [IDX_W-1:0]  req_i_r, req_j_r;
  logic [SLOT_W-1:0] slot_r, wr_ptr_r;
  logic [OCC_W-1:0]  occ_r;
  logic              in_fire, req_bad, pop;
  logic              slot_bad_r [DEPTH];

  assign in_ready = (!busy_r || job_r == JOB_LON1) && (occ_r < OCC_W'(DEPTH));
  assign in_fire  = in_valid && in_ready;
  assign req_bad  = ({1'b0, in_stack_index} >= stacks_r) ||
                    ({1'b0, in_slice_index} >= slices_r);

  always_comb begin
    busy_nxt = busy_r;
    job_nxt  = job_r;
    if (in_fire) begin
      busy_nxt = 1'b1;
      job_nxt  = JOB_LAT0;
    end else if (busy_r) begin
      if (job_r == JOB_LON1) busy_nxt = 1'b0;
      job_nxt = job_kind_t'(job_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      job_r    <= JOB_LAT0;
      wr_ptr_r <= '0;
      occ_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      job_r  <= job_nxt;
      if (in_fire) wr_ptr_r <= wr_ptr_r + SLOT_W'(1);
      case ({in_fire, pop})
        2'b10:   occ_r <= occ_r + OCC_W'(1);
        2'b01:   occ_r <= occ_r - OCC_W'(1);
        default: occ_r <= occ_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_i_r <= in_stack_index;
      req_j_r <= in_slice_index;
      slot_r  <= wr_ptr_r;
      slot_bad_r[wr_ptr_r] <= req_bad;
    end
  end

  // numerator and divisor for the current job
  logic [CNT_W-1:0]  ang_a, ang_b;
  logic [NW-1:0]     job_num;
  logic [DEN_W-1:0]  job_den;
  job_tag_t          job_tag;

  always_comb begin
    ang_a = {1'b0, req_i_r} + CNT_W'(job_r == JOB_LAT1);
    ang_b = {1'b0, req_j_r} + CNT_W'(job_r == JOB_LON1);
    job_tag.slot = slot_r;
    job_tag.kind = job_r;
    job_tag.quad = 2'b00;
    if (job_r == JOB_LAT0 || job_r == JOB_LAT1) begin
      job_num = (NW'(ang_a) << AB) + NW'(stacks_r);
      job_den = {stacks_r, 1'b0};
    end else begin
      job_num = (NW'(ang_b) << (AB + 1)) + NW'(slices_r);
      job_den = {slices_r, 1'b0};
    end
  end

  logic             d0_valid_r;
  logic [NW-1:0]    d0_num_r;
  logic [DEN_W-1:0] d0_den_r;
  job_tag_t         d0_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d0_valid_r <= 1'b0;
    end else begin
      d0_valid_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    d0_num_r <= job_num;
    d0_den_r <= job_den;
    d0_tag_r <= job_tag;
  end

  // divider chain, one quotient bit per cell, msb first
  logic             dv   [QW+1];
  logic [NW-1:0]    drem [QW+1];
  logic [DEN_W-1:0] dden [QW+1];
  logic [QW-1:0]    dquo [QW+1];
  job_tag_t         dtag [QW+1];

  assign dv[0]   = d0_valid_r;
  assign drem[0] = d0_num_r;
  assign dden[0] = d0_den_r;
  assign dquo[0] = '0;
  assign dtag[0] = d0_tag_r;

  for (genvar g = 0; g < QW; g++) begin : g_div
    uvst_div_cell #(.BIT(QW - 1 - g), .NW(NW), .QW(QW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (dv[g]),
      .in_rem   (drem[g]),
      .in_den   (dden[g]),
      .in_quo   (dquo[g]),
      .in_tag   (dtag[g]),
      .out_valid(dv[g+1]),
      .out_rem  (drem[g+1]),
      .out_den  (dden[g+1]),
      .out_quo  (dquo[g+1]),
      .out_tag  (dtag[g+1])
    );
  end

  // phase to quadrant and angle in q30
  logic [AB-1:0]  phase;
  logic [PW-1:0]  t_prod;
  logic           tv_r;
  logic [T_W-1:0] t_r;
  job_tag_t       t_tag_r, t_tag_nxt;

  always_comb begin
    if (dtag[QW].kind == JOB_LAT0 || dtag[QW].kind == JOB_LAT1) begin
      phase = dquo[QW][AB-1:0] - QTR;
    end else begin
      phase = dquo[QW][AB-1:0];
    end
    t_prod = PW'(phase[AB-3:0]) * PW'(HALF_PI_Q30) + (PW'(1) << (AB - 3));
    t_tag_nxt      = dtag[QW];
    t_tag_nxt.quad = phase[AB-1:AB-2];
  end

  // t squared and series start values
  logic [63:0] t2_prod;
  logic        b0v_r;
  tay_bus_t    b0_r, b0_nxt;

  always_comb begin
    t2_prod       = 64'(t_r) * 64'(t_r) + 64'h2000_0000;
    b0_nxt.t2     = t2_prod[61:30];
    b0_nxt.term_s = TERM_W'(t_r);
    b0_nxt.term_c = ONE_Q30;
    b0_nxt.acc_s  = $signed(ACC_W'(t_r));
    b0_nxt.acc_c  = $signed(ACC_W'(ONE_Q30));
    b0_nxt.tag    = t_tag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r  <= 1'b0;
      b0v_r <= 1'b0;
    end else begin
      tv_r  <= dv[QW];
      b0v_r <= tv_r;
    end
  end

  always_ff @(posedge clk) begin
    t_r     <= t_prod[AB-2 +: T_W];
    t_tag_r <= t_tag_nxt;
    b0_r    <= b0_nxt;
  end

  // taylor chain
  logic     tv  [TAY_CELLS+1];
  tay_bus_t tb  [TAY_CELLS+1];

  assign tv[0] = b0v_r;
  assign tb[0] = b0_r;

  for (genvar g = 0; g < TAY_CELLS; g++) begin : g_tay
    uvst_taylor_cell #(.K(g + 1)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (tv[g]),
      .in_bus   (tb[g]),
      .out_valid(tv[g+1]),
      .out_bus  (tb[g+1])
    );
  end

  // quadrant map and radius products
  logic signed [SC_W-1:0] s_raw, c_raw, s_q, c_q;
  logic [SC_W-1:0]        s_abs, c_abs;
  logic                   m1_valid_r;
  logic signed [SC_W-1:0] m1_s_r, m1_c_r;
  logic [47:0]            m1_py_r, m1_pr_r;
  job_tag_t               m1_tag_r;

  always_comb begin
    s_raw = tb[TAY_CELLS].acc_s[SC_W-1:0];
    c_raw = tb[TAY_CELLS].acc_c[SC_W-1:0];
    case (tb[TAY_CELLS].tag.quad)
      2'd0:    begin s_q = s_raw;  c_q = c_raw;  end
      2'd1:    begin s_q = c_raw;  c_q = -s_raw; end
      2'd2:    begin s_q = -s_raw; c_q = -c_raw; end
      default: begin s_q = -c_raw; c_q = s_raw;  end
    endcase
    s_abs = s_q[SC_W-1] ? SC_W'(-s_q) : SC_W'(s_q);
    c_abs = c_q[SC_W-1] ? SC_W'(-c_q) : SC_W'(c_q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r <= 1'b0;
    end else begin
      m1_valid_r <= tv[TAY_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    m1_s_r   <= s_q;
    m1_c_r   <= c_q;
    m1_py_r  <= 48'(s_abs) * 48'(radius_r);
    m1_pr_r  <= 48'(c_abs) * 48'(radius_r);
    m1_tag_r <= tb[TAY_CELLS].tag;
  end

  // round y to q14 and ring to q16
  logic [47:0]              py_rnd, pr_rnd;
  logic signed [COORD_W-1:0] y_val;
  logic signed [RING_W-1:0]  ring_val;

  always_comb begin
    py_rnd   = m1_py_r + 48'h80_0000;
    pr_rnd   = m1_pr_r + 48'h20_0000;
    y_val    = m1_s_r[SC_W-1] ? -$signed(py_rnd[24 +: COORD_W])
                              : $signed(py_rnd[24 +: COORD_W]);
    ring_val = m1_c_r[SC_W-1] ? -$signed(pr_rnd[22 +: RING_W])
                              : $signed(pr_rnd[22 +: RING_W]);
  end

  // result buffer, one entry per request slot
  logic signed [COORD_W-1:0] lat0_y_r    [DEPTH];
  logic signed [COORD_W-1:0] lat1_y_r    [DEPTH];
  logic signed [RING_W-1:0]  lat0_ring_r [DEPTH];
  logic signed [RING_W-1:0]  lat1_ring_r [DEPTH];
  logic signed [SC_W-1:0]    lon0_cos_r  [DEPTH];
  logic signed [SC_W-1:0]    lon1_cos_r  [DEPTH];
  logic signed [SC_W-1:0]    lon0_sin_r  [DEPTH];
  logic signed [SC_W-1:0]    lon1_sin_r  [DEPTH];
  logic [DEPTH-1:0]          done_r, done_nxt;
  logic [SLOT_W-1:0]         head_r;

  always_ff @(posedge clk) begin
    if (m1_valid_r) begin
      case (m1_tag_r.kind)
        JOB_LAT0: begin
          lat0_y_r[m1_tag_r.slot]    <= y_val;
          lat0_ring_r[m1_tag_r.slot] <= ring_val;
        end
        JOB_LAT1: begin
          lat1_y_r[m1_tag_r.slot]    <= y_val;
          lat1_ring_r[m1_tag_r.slot] <= ring_val;
        end
        JOB_LON0: begin
          lon0_cos_r[m1_tag_r.slot] <= m1_c_r;
          lon0_sin_r[m1_tag_r.slot] <= m1_s_r;
        end
        default: begin
          lon1_cos_r[m1_tag_r.slot] <= m1_c_r;
          lon1_sin_r[m1_tag_r.slot] <= m1_s_r;
        end
      endcase
    end
  end

  // slot complete flags: set by the last angle job, cleared on pop
  always_comb begin
    done_nxt = done_r;
    if (m1_valid_r && m1_tag_r.kind == JOB_LON1) done_nxt[m1_tag_r.slot] = 1'b1;
    if (pop) done_nxt[head_r] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
    end else begin
      done_r <= done_nxt;
    end
  end

  // vertex emitter: one vertex per cycle while not stalled, products then rounding
  logic                      a_valid_r, adv_a, adv_b, load_a, head_bad, last_v;
  logic [2:0]                vcnt_r;
  logic [1:0]                corner;
  logic signed [RING_W-1:0]  v_ring;
  logic signed [COORD_W-1:0] v_y;
  logic signed [SC_W-1:0]    v_cos, v_sin;
  logic [RING_W-1:0]         ring_abs;
  logic [SC_W-1:0]           cos_abs, sin_abs;
  logic [57:0]               a_px_r, a_pz_r, px_nxt, pz_nxt;
  logic                      a_negx_r, a_negz_r, a_last_r, a_bad_r;
  logic signed [COORD_W-1:0] a_y_r, a_y_nxt;

  assign adv_b    = !out_valid || out_ready;
  assign adv_a    = !a_valid_r || adv_b;
  assign load_a   = adv_a && done_r[head_r];
  assign head_bad = slot_bad_r[head_r];
  assign last_v   = head_bad || (vcnt_r == 3'd5);
  assign pop      = load_a && last_v;

  always_comb begin
    corner   = vtx_corner(vcnt_r);
    v_ring   = corner[1] ? lat1_ring_r[head_r] : lat0_ring_r[head_r];
    v_y      = corner[1] ? lat1_y_r[head_r]    : lat0_y_r[head_r];
    v_cos    = corner[0] ? lon1_cos_r[head_r]  : lon0_cos_r[head_r];
    v_sin    = corner[0] ? lon1_sin_r[head_r]  : lon0_sin_r[head_r];
    ring_abs = v_ring[RING_W-1] ? RING_W'(-v_ring) : RING_W'(v_ring);
    cos_abs  = v_cos[SC_W-1] ? SC_W'(-v_cos) : SC_W'(v_cos);
    sin_abs  = v_sin[SC_W-1] ? SC_W'(-v_sin) : SC_W'(v_sin);
    px_nxt   = 58'(ring_abs) * 58'(cos_abs);
    pz_nxt   = 58'(ring_abs) * 58'(sin_abs);
    a_y_nxt  = v_y;
    if (head_bad) begin
      px_nxt  = '0;
      pz_nxt  = '0;
      a_y_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      head_r    <= '0;
      vcnt_r    <= '0;
    end else begin
      if (adv_a) a_valid_r <= load_a;
      if (pop) begin
        head_r <= head_r + SLOT_W'(1);
        vcnt_r <= '0;
      end else if (load_a) begin
        vcnt_r <= vcnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      a_px_r   <= px_nxt;
      a_pz_r   <= pz_nxt;
      a_negx_r <= v_ring[RING_W-1] ^ v_cos[SC_W-1];
      a_negz_r <= v_ring[RING_W-1] ^ v_sin[SC_W-1];
      a_y_r    <= a_y_nxt;
      a_last_r <= last_v;
      a_bad_r  <= head_bad;
    end
  end

  // output word register, rounding q46 to q14
  logic [57:0]               px_rnd, pz_rnd;
  logic signed [COORD_W-1:0] x_nxt, z_nxt;
  logic                      out_valid_r, out_last_r, out_bad_r;
  logic signed [COORD_W-1:0] out_x_r, out_y_r, out_z_r;

  always_comb begin
    px_rnd = a_px_r + 58'h8000_0000;
    pz_rnd = a_pz_r + 58'h8000_0000;
    x_nxt  = a_negx_r ? -$signed(px_rnd[32 +: COORD_W]) : $signed(px_rnd[32 +: COORD_W]);
    z_nxt  = a_negz_r ? -$signed(pz_rnd[32 +: COORD_W]) : $signed(pz_rnd[32 +: COORD_W]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_b) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b && a_valid_r) begin
      out_x_r    <= x_nxt;
      out_y_r    <= a_y_r;
      out_z_r    <= z_nxt;
      out_last_r <= a_last_r;
      out_bad_r  <= a_bad_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_vertex_x    = out_x_r;
  assign out_vertex_y    = out_y_r;
  assign out_vertex_z    = out_z_r;
  assign out_last_vertex = out_last_r;
  assign out_bad_index   = out_bad_r;

  // checks
  `UVST_ASSERT_IMP(a_occ_bound, 1'b1, occ_r <= OCC_W'(DEPTH), "slot count over depth")
  `UVST_ASSERT_IMP(a_done_fresh, m1_valid_r && m1_tag_r.kind == JOB_LON1,
                   !done_r[m1_tag_r.slot], "slot completed twice")
  `UVST_ASSERT_NXT(a_issue_busy, in_valid && in_ready, busy_r, "issuer idle after accept")
  `UVST_ASSERT_IMP(a_pop_has_item, pop, occ_r != '0, "pop with no request in flight")
  `UVST_ASSERT_IMP(a_bad_is_last, out_valid && out_bad_index, out_last_vertex,
                   "error word without last flag")

endmodule
`default_nettype wire

// ===== sv/uvst_div_cell.sv =====
// one restoring-division cell: decides one quotient bit and passes the rest on
`default_nettype none
module uvst_div_cell import uvst_pkg::*; #(
  parameter int BIT = 0,
  parameter int NW  = 28,
  parameter int QW  = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [NW-1:0]    in_rem,
  input  logic [DEN_W-1:0] in_den,
  input  logic [QW-1:0]    in_quo,
  input  job_tag_t         in_tag,
  output logic             out_valid,
  output logic [NW-1:0]    out_rem,
  output logic [DEN_W-1:0] out_den,
  output logic [QW-1:0]    out_quo,
  output job_tag_t         out_tag
);

  logic             valid_r;
  logic [NW-1:0]    rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [QW-1:0]    quo_r, quo_nxt;
  job_tag_t         tag_r;
  logic [NW-1:0]    den_sh;
  logic             take;

  // trial subtract of the shifted divisor
  always_comb begin
    den_sh  = {{(NW-DEN_W){1'b0}}, in_den} << BIT;
    take    = (in_rem >= den_sh);
    rem_nxt = take ? (in_rem - den_sh) : in_rem;
    quo_nxt = in_quo;
    quo_nxt[BIT] = take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= in_den;
    quo_r <= quo_nxt;
    tag_r <= in_tag;
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_den   = den_r;
  assign out_quo   = quo_r;
  assign out_tag   = tag_r;

endmodule
`default_nettype wire

// ===== sv/uvst_taylor_cell.sv =====
// one taylor cell: next sin and cos terms (cos only past SIN_TERMS), three register stages
`default_nettype none
module uvst_taylor_cell import uvst_pkg::*; #(
  parameter int K = 1
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  tay_bus_t in_bus,
  output logic     out_valid,
  output tay_bus_t out_bus
);

  localparam longint unsigned D_S = 64'(2 * K * (2 * K + 1));
  localparam longint unsigned D_C = 64'((2 * K - 1) * (2 * K));
  localparam longint unsigned M_S = (64'd1 << 32) / D_S;
  localparam longint unsigned M_C = (64'd1 << 32) / D_C;
  localparam bit SIN_ON = (K <= SIN_TERMS);
  localparam bit SUB    = ((K % 2) == 1);

  logic        v1_r, v2_r, v3_r;
  tay_bus_t    bus1_r, bus2_r, bus3_r, bus3_nxt;
  logic [31:0] xs1_r, xc1_r, xs1_nxt, xc1_nxt;
  logic [31:0] xs2_r, xc2_r;
  logic [63:0] ys2_r, yc2_r, ys2_nxt, yc2_nxt;
  logic [63:0] ps, pc;
  logic [31:0] q0s, q0c, qs, qc;
  logic [40:0] qds, qdc, rs, rc;

  // stage 1: term times t squared, rounded from q60 to q30
  always_comb begin
    ps = 64'(in_bus.term_s) * 64'(in_bus.t2) + 64'h2000_0000;
    pc = 64'(in_bus.term_c) * 64'(in_bus.t2) + 64'h2000_0000;
    xs1_nxt = ps[61:30];
    xc1_nxt = pc[61:30];
  end

  // stage 2: reciprocal multiply for the factorial step
  always_comb begin
    ys2_nxt = 64'(xs1_r) * 64'(M_S[31:0]);
    yc2_nxt = 64'(xc1_r) * 64'(M_C[31:0]);
  end

  // stage 3: correct the estimate and accumulate
  always_comb begin
    q0s = ys2_r[63:32];
    q0c = yc2_r[63:32];
    qds = 41'(q0s) * 41'(D_S[8:0]);
    qdc = 41'(q0c) * 41'(D_C[8:0]);
    rs  = 41'(xs2_r) - qds;
    rc  = 41'(xc2_r) - qdc;
    qs  = q0s + 32'(rs >= 41'(D_S[8:0]));
    qc  = q0c + 32'(rc >= 41'(D_C[8:0]));
    bus3_nxt = bus2_r;
    if (SIN_ON) begin
      bus3_nxt.term_s = qs;
      bus3_nxt.acc_s  = SUB ? (bus2_r.acc_s - $signed({2'b00, qs}))
                            : (bus2_r.acc_s + $signed({2'b00, qs}));
    end
    bus3_nxt.term_c = qc;
    bus3_nxt.acc_c  = SUB ? (bus2_r.acc_c - $signed({2'b00, qc}))
                          : (bus2_r.acc_c + $signed({2'b00, qc}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    bus1_r <= in_bus;
    xs1_r  <= xs1_nxt;
    xc1_r  <= xc1_nxt;
    bus2_r <= bus1_r;
    xs2_r  <= xs1_r;
    xc2_r  <= xc1_r;
    ys2_r  <= ys2_nxt;
    yc2_r  <= yc2_nxt;
    bus3_r <= bus3_nxt;
  end

  assign out_valid = v3_r;
  assign out_bus   = bus3_r;

endmodule
`default_nettype wire
